FILE: src/gtc_pkg.sv
package gtc_pkg;

  // Width of one adjacency row and of the lane array.
  localparam int ROW_W   = 16;
  // Width of a node index and of a component number.
  localparam int NODE_W  = 4;
  // Width of the node and component counts.
  localparam int COUNT_W = 5;

  // Input item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Traversal orders.
  localparam logic ORDER_DFS = 1'b0;
  localparam logic ORDER_BFS = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_ORDER      = 1'b1;

  // Outcome of the search across the lanes.
  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] idx;
  } lane_result_t;

endpackage

FILE: src/graph_traversal_components.sv
// Connected-component traversal of a small graph held as an adjacency matrix.
// Input channel (in_*): a transfer with in_tuser = load writes one matrix row
// (in_tdata row_index and row_bits). A transfer
// with in_tuser = run traverses nodes 0 to node_count-1 and sends one result
// per node on the output channel (out_*), in discovery order, with its
// component number; the final result has out_tlast set and carries the
// component count and the connected flag. Every row in use must be loaded
// before a run.
// A run takes one traversal step per cycle unless the output register stalls:
// each node costs one step when it is discovered, and every node but the
// last to be discovered may cost one more when it leaves the stack or
// queue. The run ends with its final discovery, so it has at most
// 2 * node_count - 1 steps (31 at sixteen nodes). An accepted run sets the
// run state register, and its first result then enters the output register.
// Each step is one pass of the sixteen compare lanes and their priority merge
// over the current row word. in_tready is low while a run is in progress.
// Reset sets node_count to 16, picks depth-first order and empties the
// output register; the adjacency rows keep whatever they held.
module graph_traversal_components
  import gtc_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: row_index[3:0], row_bits[19:4], zero padding[23:20].
  input  logic [23:0] in_tdata,
  // Fields from bit 0: kind[0].
  input  logic        in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: node[3:0], component[7:4], component_count[12:8],
  // connected[13], zero padding[15:14].
  output logic [15:0] out_tdata,
  // Fields from bit 0: starts_component[0].
  output logic        out_tuser,
  output logic        out_tlast
);

  // Rows that can ever be in use: bounded by the parameter and the row width.
  localparam int NROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int IDX_W = $clog2(NROWS);
  localparam int PTR_W = $clog2(NROWS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  // Configuration registers.
  logic [COUNT_W-1:0] node_count_r;
  logic               order_r;

  // Traversal state.
  logic                 state_r;
  logic [ROW_W-1:0]     adj_r [NROWS];
  logic [NODE_W-1:0]    wl_r [NROWS];
  logic [ROW_W-1:0]     visited_r;
  logic [PTR_W-1:0]     head_r, tail_r;
  logic [COUNT_W-1:0]   comp_r;
  logic [COUNT_W-1:0]   emit_cnt_r;

  // Output register.
  logic                 out_valid_r;
  logic [NODE_W-1:0]    out_node_r;
  logic [NODE_W-1:0]    out_comp_r;
  logic                 out_root_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_conn_r;
  logic                 out_last_r;

  logic [COUNT_W-1:0]   n_act;
  logic                 in_fire;
  logic                 step_en;
  logic                 list_empty;
  logic [PTR_W-1:0]     front_ptr;
  logic [NODE_W-1:0]    front_node;
  logic [ROW_W-1:0]     scan_row;
  logic [ROW_W-1:0]     cand;
  lane_result_t         pick;
  logic                 emit;
  logic [COUNT_W-1:0]   comp_nxt;
  logic [COUNT_W-1:0]   emit_cnt_nxt;
  logic [NODE_W-1:0]    in_row_index;
  logic [ROW_W-1:0]     in_row_bits;

  assign in_row_index = in_tdata[3:0];
  assign in_row_bits  = in_tdata[19:4];

  // Node count in use: zero acts as one, and it never exceeds the row store.
  always_comb begin
    if (node_count_r == '0) begin
      n_act = COUNT_W'(1);
    end else if (node_count_r > COUNT_W'(NROWS)) begin
      n_act = COUNT_W'(NROWS);
    end else begin
      n_act = node_count_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // A step may produce a result, so it waits for a free output register.
  assign step_en   = (state_r == S_RUN) && (!out_valid_r || out_tready);

  // The work list is a stack (head fixed at zero) or a queue; either way it
  // is empty when head and tail meet.
  assign list_empty = (head_r == tail_r);
  assign front_ptr  = (order_r == ORDER_DFS) ? (tail_r - PTR_W'(1)) : head_r;
  assign front_node = wl_r[front_ptr[IDX_W-1:0]];

  // With an empty list the lanes search for the next root among all nodes.
  assign scan_row = list_empty ? {ROW_W{1'b1}} : adj_r[front_node[IDX_W-1:0]];

  gtc_lanes u_lanes (
    .row_bits (scan_row),
    .visited  (visited_r),
    .n_act    (n_act),
    .cand     (cand)
  );

  gtc_merge u_merge (
    .cand (cand),
    .res  (pick)
  );

  assign emit         = step_en && pick.found;
  assign comp_nxt     = list_empty ? (comp_r + COUNT_W'(1)) : comp_r;
  assign emit_cnt_nxt = emit_cnt_r + COUNT_W'(1);

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_W'(16);
      order_r      <= ORDER_DFS;
      state_r      <= S_IDLE;
      visited_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      comp_r       <= '0;
      emit_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_wdata;
          CFG_ORDER:      order_r      <= cfg_wdata[0];
          default:        ;
        endcase
      end

      // A result leaving without a new one behind it empties the register.
      if (out_valid_r && out_tready && !emit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_tuser == KIND_RUN) begin
            state_r    <= S_RUN;
            visited_r  <= '0;
            head_r     <= '0;
            tail_r     <= '0;
            comp_r     <= '0;
            emit_cnt_r <= '0;
          end
        end
        S_RUN: begin
          if (step_en) begin
            if (pick.found) begin
              visited_r[pick.idx] <= 1'b1;
              comp_r              <= comp_nxt;
              emit_cnt_r          <= emit_cnt_nxt;
              out_valid_r         <= 1'b1;
              if (list_empty) begin
                head_r <= '0;
                tail_r <= PTR_W'(1);
              end else begin
                tail_r <= tail_r + PTR_W'(1);
              end
              if (emit_cnt_nxt == n_act) begin
                state_r <= S_IDLE;
              end
            end else if (list_empty) begin
              // Nothing left to find; only reached if the count went astray.
              state_r <= S_IDLE;
            end else if (order_r == ORDER_DFS) begin
              tail_r <= tail_r - PTR_W'(1);
            end else begin
              head_r <= head_r + PTR_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Row store and work list, and the result payload.
  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == KIND_LOAD && (32'(in_row_index) < NROWS)) begin
      adj_r[in_row_index[IDX_W-1:0]] <= in_row_bits;
    end
    if (emit) begin
      if (list_empty) begin
        wl_r[0] <= pick.idx;
      end else begin
        wl_r[tail_r[IDX_W-1:0]] <= pick.idx;
      end
      out_node_r  <= pick.idx;
      out_comp_r  <= NODE_W'(comp_nxt - COUNT_W'(1));
      out_root_r  <= list_empty;
      out_last_r  <= (emit_cnt_nxt == n_act);
      out_count_r <= (emit_cnt_nxt == n_act) ? comp_nxt : '0;
      out_conn_r  <= (emit_cnt_nxt == n_act) && (comp_nxt == COUNT_W'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_conn_r, out_count_r, out_comp_r, out_node_r};
  assign out_tuser  = out_root_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // A run never emits more results than there are nodes in use.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (emit_cnt_r < n_act))
    else $error("emitted count reached node count while running");

  // A node is only ever discovered once per run.
  a_fresh_node: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !visited_r[pick.idx])
    else $error("node discovered twice");

  // The work list never grows past the row store.
  a_list_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r <= PTR_W'(NROWS)) && (head_r <= tail_r))
    else $error("work list pointers out of range");

  // The final result of a run always reports at least one component.
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_count_r != '0))
    else $error("final result carries no component count");
`endif

endmodule

FILE: src/gtc_lanes.sv
module gtc_lanes
  import gtc_pkg::*;
(
  input  logic [ROW_W-1:0]   row_bits,
  input  logic [ROW_W-1:0]   visited,
  input  logic [COUNT_W-1:0] n_act,
  output logic [ROW_W-1:0]   cand
);

  // Each lane looks at one node: an edge to it, not yet visited, and in use.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      cand[j] = row_bits[j] && !visited[j] && (COUNT_W'(j) < n_act);
    end
  end

endmodule

FILE: src/gtc_merge.sv
module gtc_merge
  import gtc_pkg::*;
(
  input  logic [ROW_W-1:0] cand,
  output lane_result_t     res
);

  // The lowest lane that found a candidate wins.
  always_comb begin
    res.found = 1'b0;
    res.idx   = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        res.found = 1'b1;
        res.idx   = NODE_W'(j);
      end
    end
  end

endmodule

FILE: verif/gtc_tb_pkg.sv
`timescale 1ns / 1ps

package gtc_tb_pkg;
  import gtc_pkg::*;

  localparam int NODES = 16;

  // One node visit as it should appear on the result channel.
  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  component;
    logic               starts;
    logic [COUNT_W-1:0] count;
    logic               connected;
    logic               last;
  } visit_t;

  class traversal_scoreboard;
    logic [ROW_W-1:0]   row_store [NODES];
    logic [COUNT_W-1:0] node_count;
    logic               order;
    visit_t             expected_visits [$];
    int unsigned        mismatches;

    function new();
      node_count = COUNT_W'(NODES);
      order      = ORDER_DFS;
      mismatches = 0;
      foreach (row_store[i]) row_store[i] = '0;
    endfunction

    function void set_register(logic idx, logic [4:0] value);
      if (idx == CFG_NODE_COUNT) node_count = value;
      else order = value[0];
    endfunction

    function int pending();
      return expected_visits.size();
    endfunction

    function int unsigned error_count();
      return mismatches;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Works out every visit of one run from the stored rows.
    function void predict_traversal();
      int     n, cur, head, comp;
      int     work [$];
      bit [NODES-1:0] seen;
      visit_t v;
      visit_t run_out [$];
      n = (node_count == 0) ? 1 : ((node_count > NODES) ? NODES : int'(node_count));
      seen = '0;
      comp = 0;
      for (int i = 0; i < n; i++) begin
        if (seen[i]) continue;
        seen[i] = 1'b1;
        v = '{node: NODE_W'(i), component: NODE_W'(comp), starts: 1'b1,
              count: '0, connected: 1'b0, last: 1'b0};
        run_out.push_back(v);
        work.delete();
        work.push_back(i);
        if (order == ORDER_DFS) begin
          while (work.size() > 0) begin
            int nb;
            cur = work[work.size()-1];
            nb = n;
            for (int j = n - 1; j >= 0; j--) begin
              if (row_store[cur][j] && !seen[j]) nb = j;
            end
            if (nb < n) begin
              seen[nb] = 1'b1;
              v = '{node: NODE_W'(nb), component: NODE_W'(comp), starts: 1'b0,
                    count: '0, connected: 1'b0, last: 1'b0};
              run_out.push_back(v);
              work.push_back(nb);
            end else begin
              void'(work.pop_back());
            end
          end
        end else begin
          head = 0;
          while (head < work.size()) begin
            cur = work[head];
            head++;
            for (int nb = 0; nb < n; nb++) begin
              if (row_store[cur][nb] && !seen[nb]) begin
                seen[nb] = 1'b1;
                v = '{node: NODE_W'(nb), component: NODE_W'(comp), starts: 1'b0,
                      count: '0, connected: 1'b0, last: 1'b0};
                run_out.push_back(v);
                work.push_back(nb);
              end
            end
          end
        end
        comp++;
      end
      v = run_out.pop_back();
      v.count     = COUNT_W'(comp);
      v.connected = (comp == 1);
      v.last      = 1'b1;
      run_out.push_back(v);
      foreach (run_out[k]) expected_visits.push_back(run_out[k]);
    endfunction

    function void note_item(logic kind, logic [3:0] row, logic [ROW_W-1:0] bits);
      if (kind == KIND_LOAD) row_store[row] = bits;
      else predict_traversal();
    endfunction

    task check_result(logic [15:0] tdata, logic tuser, logic tlast);
      visit_t got, want;
      got = '{node: tdata[3:0], component: tdata[7:4], starts: tuser,
              count: tdata[12:8], connected: tdata[13], last: tlast};
      if (expected_visits.size() == 0) begin
        report($sformatf("result node %0d with none expected", got.node));
        return;
      end
      want = expected_visits.pop_front();
      if (got.node != want.node)
        report($sformatf("node %0d, want %0d", got.node, want.node));
      if (got.component != want.component)
        report($sformatf("component %0d, want %0d", got.component, want.component));
      if (got.starts != want.starts)
        report($sformatf("starts_component %0d, want %0d", got.starts, want.starts));
      if (got.count != want.count)
        report($sformatf("component_count %0d, want %0d", got.count, want.count));
      if (got.connected != want.connected)
        report($sformatf("connected %0d, want %0d", got.connected, want.connected));
      if (got.last != want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

endpackage

FILE: verif/tb_graph_traversal_components.sv
`timescale 1ns / 1ps

module tb_graph_traversal_components;
  import gtc_pkg::*;
  import gtc_tb_pkg::*;

  // The block is already idle once the last result of a run has left; these
  // spare cycles only put some distance between the phases.
  localparam int DRAIN_CYCLES = 48;
  // Far above the slowest correct run, with every gap and stall at its worst.
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [4:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned rx_hold    = 0;
  int unsigned cycle_count = 0;

  traversal_scoreboard sb = new();

  graph_traversal_components #(
    .MAX_NODES(16)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Give up if the run hangs, for instance when results never arrive.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("graph_traversal_components verification failed");
      $finish;
    end
  end

  // Result side. Every accepted transfer is checked against the oldest
  // expected visit; afterwards tready is held low for a freshly drawn number
  // of cycles, so that stalls land on every step of a traversal.
  always @(posedge clk) begin : result_side
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
      hold = $urandom_range(0, rx_gap_max);
      out_tready <= (hold == 0);
      rx_hold    <= hold;
    end else if (!out_tready) begin
      if (rx_hold <= 1) begin
        out_tready <= 1'b1;
        rx_hold    <= 0;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // Presents one input item after a random gap and waits for its transfer.
  // tvalid is only lowered when a gap follows, so back-to-back items keep it
  // high without a second assignment in the same time step.
  task automatic send_item(input logic kind, input logic [3:0] row,
                           input logic [ROW_W-1:0] bits);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, bits, row};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, row, bits);
  endtask

  // Stops sending and waits until every expected visit has come out, then
  // idles for the drain time set by DRAIN_CYCLES.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // Row words of varied density: sparse ones split the graph into many
  // components, dense ones join it up, and the two extremes turn up too.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a, b, c;
    a = ROW_W'($urandom);
    b = ROW_W'($urandom);
    c = ROW_W'($urandom);
    case ($urandom_range(0, 7))
      0, 1:    return a & b & c;
      2, 3:    return a & b;
      4:       return a;
      5:       return a | b;
      6:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin : stimulus
    int          cnt, active;
    logic [ROW_W-1:0] bits;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A single node with a full row: the self edge and the
    // edges beyond the node count must both be ignored.
    tx_gap_max = 0;
    rx_gap_max = 15;
    write_reg(CFG_NODE_COUNT, 5'd1);
    write_reg(CFG_ORDER, {4'b0000, ORDER_DFS});
    send_item(KIND_LOAD, 4'd0, 16'hFFFF);
    send_item(KIND_RUN, 4'd15, 16'hFFFF);

    // A node count of zero behaves as one.
    wait_idle();
    write_reg(CFG_NODE_COUNT, 5'd0);
    write_reg(CFG_ORDER, {4'b0000, ORDER_BFS});
    send_item(KIND_RUN, 4'd0, 16'h0000);

    // The largest register value saturates to sixteen nodes. Rows 0 and 15
    // reach everything and the rest are empty, so the graph is connected.
    wait_idle();
    write_reg(CFG_NODE_COUNT, 5'd31);
    write_reg(CFG_ORDER, {4'b0000, ORDER_DFS});
    for (int i = 0; i < NODES; i++) begin
      bits = (i == 0 || i == NODES - 1) ? 16'hFFFF : 16'h0000;
      send_item(KIND_LOAD, 4'(i), bits);
    end
    send_item(KIND_RUN, 4'd0, 16'h0000);
    wait_idle();
    write_reg(CFG_ORDER, {4'b0000, ORDER_BFS});
    send_item(KIND_RUN, 4'd7, 16'h5A5A);

    // With every row empty each node is a component of its own: sixteen
    // components is the most that a run can report.
    send_item(KIND_LOAD, 4'd0, 16'h0000);
    send_item(KIND_LOAD, 4'd15, 16'h0000);
    send_item(KIND_RUN, 4'd3, 16'hFFFF);

    // Random part in phases. Every row has been loaded by now, so a run may
    // follow at any point. Each phase sets both registers while the block is
    // idle and then mixes loads, mostly to rows in use, with runs.
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      case (phase)
        0:       cnt = 16;
        1:       cnt = 1;
        2:       cnt = 0;
        3:       cnt = 31;
        4:       cnt = 2;
        default: cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                   : $urandom_range(1, 16);
      endcase
      write_reg(CFG_NODE_COUNT, 5'(cnt));
      if (phase < 4)
        write_reg(CFG_ORDER, {4'b0000, (phase % 2 == 1) ? ORDER_BFS : ORDER_DFS});
      else
        write_reg(CFG_ORDER, 5'($urandom_range(0, 1)));
      active = (cnt == 0) ? 1 : ((cnt > NODES) ? NODES : cnt);

      // The first phase runs flat out on both sides; later ones idle at random.
      tx_gap_max = (phase == 0 || $urandom_range(0, 2) == 0) ? 0 : 15;
      rx_gap_max = (phase == 0 || $urandom_range(0, 2) == 0) ? 0 : 15;

      for (int item = 0; item < 27; item++) begin
        // Now and then hold the sender back until the results have drained.
        if (item == 13 && phase % 3 == 0) wait_idle();
        if ($urandom_range(0, 3) == 0)
          send_item(KIND_RUN, 4'($urandom), random_row());
        else if ($urandom_range(0, 3) != 0)
          send_item(KIND_LOAD, 4'($urandom_range(0, active - 1)), random_row());
        else
          send_item(KIND_LOAD, 4'($urandom_range(0, 15)), random_row());
      end
    end

    wait_idle();
    if (sb.error_count() == 0)
      $display("graph_traversal_components verification clean");
    else
      $display("graph_traversal_components verification failed");
    $finish;
  end

endmodule
